// File: rtl/core/quorum_lock_voting_node_unit_defines.svh
// ----------------------------------------------------------------------------
// Quorum lock voting node - assertion macro
// Shared macro for the port-level checks of the voting node.
// ----------------------------------------------------------------------------
`ifndef QUORUM_LOCK_VOTING_NODE_UNIT_DEFINES_SVH
`define QUORUM_LOCK_VOTING_NODE_UNIT_DEFINES_SVH

// implication check, reset-gated
`define QLVN_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qlvn check failed");

`endif

// File: rtl/core/qlvn_pkg.sv
// ----------------------------------------------------------------------------
// Quorum lock voting node - package
// Constants, codes and types shared by the node's modules.
// ----------------------------------------------------------------------------
package qlvn_pkg;

  localparam int MAX_NODES   = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int NODE_W      = 5;
  localparam int STAMP_W     = 32;
  localparam int KEY_W       = STAMP_W + NODE_W;
  localparam int CNT_W       = 6;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int SCAN_W      = SLOT_W + 1;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [2:0] {
    FN_REQUEST    = 3'd0,
    FN_LOCKED     = 3'd1,
    FN_INQUIRE    = 3'd2,
    FN_RELEASE    = 3'd3,
    FN_RELINQUISH = 3'd4,
    FN_FAILED     = 3'd5,
    FN_COMPLETE   = 3'd6,
    FN_START      = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    K_LOCKED     = 2'd0,
    K_INQUIRE    = 2'd1,
    K_FAILED     = 2'd2,
    K_RELINQUISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_QUORUM   = 2'd0,
    CFG_NODES    = 2'd1,
    CFG_COMPLETE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRE,
    ST_SCAN,
    ST_POST,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/quorum_lock_voting_node_unit.sv
// Path: simple messages pass EXEC and OUT; release, and relinquish while the vote
// is held, also pass SCAN and POST, and a queued request PRE before them; a stalled
// result waits in OUT. Throughput: one item at a time; the queue scan reads one
// slot per cycle through the slot RAM port and the single shared comparator.
// Reset: synchronous, active low; vote free, queue empty, marks and tallies
// cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
// Quorum lock voting node - top level
// Voting and requesting halves of one quorum node under a small sequencer.
// ----------------------------------------------------------------------------
module quorum_lock_voting_node_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [qlvn_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_func,
  input  logic [qlvn_pkg::NODE_W-1:0]    in_sender_node,
  input  logic [qlvn_pkg::STAMP_W-1:0]   in_stamp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_send_valid,
  output logic [1:0]                     out_send_kind,
  output logic [qlvn_pkg::NODE_W-1:0]    out_send_dest,
  output logic [qlvn_pkg::CNT_W-1:0]     out_votes_granted,
  output logic                           out_lock_held,
  output logic                           out_queue_dropped,
  output logic                           out_all_complete
);

  localparam int QD = qlvn_pkg::QUEUE_DEPTH;
  localparam int MN = qlvn_pkg::MAX_NODES;

  qlvn_pkg::state_t state_r, state_nxt;

  logic [qlvn_pkg::CNT_W-1:0]  quorum_r, quorum_nxt;
  logic [qlvn_pkg::CNT_W-1:0]  nodes_r, nodes_nxt;

  logic [2:0]                  func_r, func_nxt;
  qlvn_pkg::key_t              new_r, new_nxt;

  logic                        vote_r, vote_nxt;
  qlvn_pkg::key_t              holder_r, holder_nxt;
  logic [QD-1:0]               used_r, used_nxt;
  logic                        inq_r, inq_nxt;
  logic [qlvn_pkg::CNT_W-1:0]  granted_r, granted_nxt;
  logic [MN-1:0]               failed_r, failed_nxt;
  logic [qlvn_pkg::CNT_W-1:0]  done_r, done_nxt;

  logic [qlvn_pkg::SCAN_W-1:0] cnt_r, cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [qlvn_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic                        have_r, have_nxt;
  logic [qlvn_pkg::SLOT_W-1:0] bidx_r, bidx_nxt;
  qlvn_pkg::key_t              best_r, best_nxt;
  logic                        fail_r, fail_nxt;
  logic [qlvn_pkg::SLOT_W-1:0] free_r, free_nxt;

  logic                        rsv_r, rsv_nxt;
  logic [1:0]                  rkind_r, rkind_nxt;
  logic [qlvn_pkg::NODE_W-1:0] rdest_r, rdest_nxt;
  logic                        rdrop_r, rdrop_nxt;

  logic                        ov_r, ov_nxt;
  logic                        osv_r, osv_nxt;
  logic [1:0]                  okind_r, okind_nxt;
  logic [qlvn_pkg::NODE_W-1:0] odest_r, odest_nxt;
  logic [qlvn_pkg::CNT_W-1:0]  ovotes_r, ovotes_nxt;
  logic                        olock_r, olock_nxt;
  logic                        odrop_r, odrop_nxt;
  logic                        ocomp_r, ocomp_nxt;

  logic                        ram_we;
  logic [qlvn_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
  qlvn_pkg::key_t              ram_wdata, ram_rdata;
  qlvn_pkg::key_t              cmp_a, cmp_b;
  logic                        cmp_lt;

  logic                        free_any;
  logic [qlvn_pkg::SLOT_W-1:0] free_idx;
  logic [MN-1:0]               node_mask;
  logic                        any_failed;

  qlvn_ram #(.WIDTH(qlvn_pkg::KEY_W), .DEPTH(QD)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qlvn_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .earlier (cmp_lt)
  );

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = QD - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        free_any = 1'b1;
        free_idx = qlvn_pkg::SLOT_W'(s);
      end
    end
  end

  always_comb begin
    for (int x = 0; x < MN; x++) begin
      node_mask[x] = (qlvn_pkg::CNT_W'(x) < nodes_r);
    end
  end

  assign any_failed = |(failed_r & node_mask);

  always_comb begin
    case (state_r)
      qlvn_pkg::ST_PRE: begin
        cmp_a = holder_r;
        cmp_b = new_r;
      end
      qlvn_pkg::ST_POST: begin
        cmp_a = best_r;
        cmp_b = holder_r;
      end
      default: begin
        cmp_a = ram_rdata;
        cmp_b = (func_r == qlvn_pkg::FN_REQUEST) ? new_r : best_r;
      end
    endcase
  end

  assign ram_raddr = cnt_r[qlvn_pkg::SLOT_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    quorum_nxt  = quorum_r;
    nodes_nxt   = nodes_r;
    func_nxt    = func_r;
    new_nxt     = new_r;
    vote_nxt    = vote_r;
    holder_nxt  = holder_r;
    used_nxt    = used_r;
    inq_nxt     = inq_r;
    granted_nxt = granted_r;
    failed_nxt  = failed_r;
    done_nxt    = done_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    idx_nxt     = idx_r;
    have_nxt    = have_r;
    bidx_nxt    = bidx_r;
    best_nxt    = best_r;
    fail_nxt    = fail_r;
    free_nxt    = free_r;
    rsv_nxt     = rsv_r;
    rkind_nxt   = rkind_r;
    rdest_nxt   = rdest_r;
    rdrop_nxt   = rdrop_r;
    ov_nxt      = ov_r;
    osv_nxt     = osv_r;
    okind_nxt   = okind_r;
    odest_nxt   = odest_r;
    ovotes_nxt  = ovotes_r;
    olock_nxt   = olock_r;
    odrop_nxt   = odrop_r;
    ocomp_nxt   = ocomp_r;
    ram_we      = 1'b0;
    ram_waddr   = free_r;
    ram_wdata   = new_r;
    in_stall    = (state_r != qlvn_pkg::ST_IDLE);

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        qlvn_pkg::CFG_QUORUM:   quorum_nxt = cfg_wdata;
        qlvn_pkg::CFG_NODES:    nodes_nxt  = cfg_wdata;
        qlvn_pkg::CFG_COMPLETE: done_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      qlvn_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          new_nxt   = {in_stamp, in_sender_node};
          state_nxt = qlvn_pkg::ST_EXEC;
        end
      end
      qlvn_pkg::ST_EXEC: begin
        rsv_nxt   = 1'b0;
        rkind_nxt = qlvn_pkg::K_LOCKED;
        rdest_nxt = '0;
        rdrop_nxt = 1'b0;
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        have_nxt  = 1'b0;
        state_nxt = qlvn_pkg::ST_OUT;
        case (func_r)
          qlvn_pkg::FN_REQUEST: begin
            if (!vote_r) begin
              vote_nxt   = 1'b1;
              holder_nxt = new_r;
              inq_nxt    = 1'b0;
              rsv_nxt    = 1'b1;
              rdest_nxt  = new_r[qlvn_pkg::NODE_W-1:0];
            end else if (!free_any) begin
              rdrop_nxt = 1'b1;
            end else begin
              free_nxt  = free_idx;
              state_nxt = qlvn_pkg::ST_PRE;
            end
          end
          qlvn_pkg::FN_LOCKED: begin
            if (granted_r != '1) granted_nxt = granted_r + 1'b1;
            failed_nxt[new_r[qlvn_pkg::NODE_W-1:0]] = 1'b0;
          end
          qlvn_pkg::FN_INQUIRE: begin
            if (any_failed) begin
              if (granted_r != '0) granted_nxt = granted_r - 1'b1;
              rsv_nxt   = 1'b1;
              rkind_nxt = qlvn_pkg::K_RELINQUISH;
              rdest_nxt = new_r[qlvn_pkg::NODE_W-1:0];
            end
          end
          qlvn_pkg::FN_RELEASE: begin
            state_nxt = qlvn_pkg::ST_SCAN;
          end
          qlvn_pkg::FN_RELINQUISH: begin
            if (vote_r) state_nxt = qlvn_pkg::ST_SCAN;
          end
          qlvn_pkg::FN_FAILED: begin
            failed_nxt[new_r[qlvn_pkg::NODE_W-1:0]] = 1'b1;
          end
          qlvn_pkg::FN_COMPLETE: begin
            if (done_r != '1) done_nxt = done_r + 1'b1;
          end
          default: begin
            granted_nxt = '0;
          end
        endcase
      end
      qlvn_pkg::ST_PRE: begin
        fail_nxt  = cmp_lt;
        state_nxt = qlvn_pkg::ST_SCAN;
      end
      qlvn_pkg::ST_SCAN: begin
        cnt_nxt  = cnt_r + 1'b1;
        pend_nxt = (cnt_r < qlvn_pkg::SCAN_W'(QD));
        idx_nxt  = cnt_r[qlvn_pkg::SLOT_W-1:0];
        if (pend_r && used_r[idx_r]) begin
          if (func_r == qlvn_pkg::FN_REQUEST) begin
            if (cmp_lt) fail_nxt = 1'b1;
          end else if (!have_r || cmp_lt) begin
            have_nxt = 1'b1;
            bidx_nxt = idx_r;
            best_nxt = ram_rdata;
          end
        end
        if (cnt_r == qlvn_pkg::SCAN_W'(QD)) state_nxt = qlvn_pkg::ST_POST;
      end
      qlvn_pkg::ST_POST: begin
        state_nxt = qlvn_pkg::ST_OUT;
        case (func_r)
          qlvn_pkg::FN_REQUEST: begin
            ram_we           = 1'b1;
            used_nxt[free_r] = 1'b1;
            if (fail_r) begin
              rsv_nxt   = 1'b1;
              rkind_nxt = qlvn_pkg::K_FAILED;
              rdest_nxt = new_r[qlvn_pkg::NODE_W-1:0];
            end else begin
              if (!inq_r) begin
                rsv_nxt   = 1'b1;
                rkind_nxt = qlvn_pkg::K_INQUIRE;
                rdest_nxt = holder_r[qlvn_pkg::NODE_W-1:0];
              end
              inq_nxt = 1'b1;
            end
          end
          qlvn_pkg::FN_RELEASE: begin
            inq_nxt = 1'b0;
            if (!have_r) begin
              vote_nxt   = 1'b0;
              holder_nxt = '0;
            end else begin
              vote_nxt         = 1'b1;
              holder_nxt       = best_r;
              used_nxt[bidx_r] = 1'b0;
              rsv_nxt          = 1'b1;
              rdest_nxt        = best_r[qlvn_pkg::NODE_W-1:0];
            end
          end
          default: begin
            rsv_nxt   = 1'b1;
            rdest_nxt = holder_r[qlvn_pkg::NODE_W-1:0];
            if (have_r && cmp_lt) begin
              ram_we     = 1'b1;
              ram_waddr  = bidx_r;
              ram_wdata  = holder_r;
              holder_nxt = best_r;
              inq_nxt    = 1'b0;
              rdest_nxt  = best_r[qlvn_pkg::NODE_W-1:0];
            end
          end
        endcase
      end
      qlvn_pkg::ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          osv_nxt    = rsv_r;
          okind_nxt  = rkind_r;
          odest_nxt  = rdest_r;
          ovotes_nxt = granted_r;
          olock_nxt  = (granted_r >= quorum_r);
          odrop_nxt  = rdrop_r;
          ocomp_nxt  = (done_r >= nodes_r);
          state_nxt  = qlvn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qlvn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= qlvn_pkg::ST_IDLE;
      quorum_r  <= qlvn_pkg::CNT_W'(3);
      nodes_r   <= qlvn_pkg::CNT_W'(4);
      vote_r    <= 1'b0;
      holder_r  <= '0;
      used_r    <= '0;
      inq_r     <= 1'b0;
      granted_r <= '0;
      failed_r  <= '0;
      done_r    <= '0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      have_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      quorum_r  <= quorum_nxt;
      nodes_r   <= nodes_nxt;
      vote_r    <= vote_nxt;
      holder_r  <= holder_nxt;
      used_r    <= used_nxt;
      inq_r     <= inq_nxt;
      granted_r <= granted_nxt;
      failed_r  <= failed_nxt;
      done_r    <= done_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      have_r    <= have_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    new_r    <= new_nxt;
    idx_r    <= idx_nxt;
    bidx_r   <= bidx_nxt;
    best_r   <= best_nxt;
    fail_r   <= fail_nxt;
    free_r   <= free_nxt;
    rsv_r    <= rsv_nxt;
    rkind_r  <= rkind_nxt;
    rdest_r  <= rdest_nxt;
    rdrop_r  <= rdrop_nxt;
    osv_r    <= osv_nxt;
    okind_r  <= okind_nxt;
    odest_r  <= odest_nxt;
    ovotes_r <= ovotes_nxt;
    olock_r  <= olock_nxt;
    odrop_r  <= odrop_nxt;
    ocomp_r  <= ocomp_nxt;
  end

  assign out_valid         = ov_r;
  assign out_send_valid    = osv_r;
  assign out_send_kind     = okind_r;
  assign out_send_dest     = odest_r;
  assign out_votes_granted = ovotes_r;
  assign out_lock_held     = olock_r;
  assign out_queue_dropped = odrop_r;
  assign out_all_complete  = ocomp_r;

endmodule

// File: rtl/core/qlvn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qlvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/qlvn_cmp.sv
// ----------------------------------------------------------------------------
// Quorum lock voting node - order comparator
// Shared unit: is key a earlier than key b (stamp first, then node index).
// ----------------------------------------------------------------------------
module qlvn_cmp (
  input  qlvn_pkg::key_t a,
  input  qlvn_pkg::key_t b,
  output logic           earlier
);

  assign earlier = (a < b);

endmodule

// File: rtl/core/qlvn_chk.sv
// ----------------------------------------------------------------------------
// Quorum lock voting node - port checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "quorum_lock_voting_node_unit_defines.svh"

module qlvn_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_send_valid,
  input logic [1:0]                   out_send_kind,
  input logic [qlvn_pkg::NODE_W-1:0]  out_send_dest,
  input logic                         out_queue_dropped
);

  `QLVN_CHK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_send_dest))
  `QLVN_CHK(a_busy_after_item, in_valid && !in_stall |=> in_stall)
  `QLVN_CHK(a_quiet_kind, out_valid && !out_send_valid |-> out_send_kind == qlvn_pkg::K_LOCKED)
  `QLVN_CHK(a_quiet_dest, out_valid && !out_send_valid |-> out_send_dest == '0)
  `QLVN_CHK(a_drop_silent, out_valid && out_queue_dropped |-> !out_send_valid)

endmodule

bind quorum_lock_voting_node_unit qlvn_chk u_qlvn_chk (.*);
